>>> sv/depthwise_same_pad_fir_defines.svh
// Assertion helpers shared by the filter RTL.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef DEPTHWISE_SAME_PAD_FIR_DEFINES_SVH
`define DEPTHWISE_SAME_PAD_FIR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dspf_pkg.sv
package dspf_pkg;

  // Filter geometry. The window spans PAD samples on either side of the center.
  localparam int TAPS      = 7;
  localparam int PAD       = TAPS / 2;
  localparam int NCELL     = 2 * PAD + 1;
  localparam int NREG      = 7;
  localparam int REG_IDX_W = $clog2(NREG);
  localparam int SEEN_W    = $clog2(PAD + 1);

  // Arithmetic: Q3.12 samples times Q1.14 taps give Q5.26 products.
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int LANES      = 8;
  localparam int SUM_W      = PROD_W + $clog2(LANES);
  localparam int FRAC_SHIFT = 14;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [LANES-1:0] prod_vec_t;

  typedef struct packed {
    sample_t sample_in;
    logic    end_of_sequence;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    last_out;
  } out_item_t;

  // Per-step control broadcast along the cell row.
  typedef struct packed {
    logic take;
    logic clear;
  } cell_ctl_t;

endpackage

>>> sv/dspf_cell.sv
module dspf_cell (
  input  logic               clk,
  input  logic               rst,
  input  dspf_pkg::cell_ctl_t ctl,
  input  dspf_pkg::sample_t  tap,
  input  dspf_pkg::sample_t  sample_in,
  output dspf_pkg::sample_t  sample,
  output dspf_pkg::prod_t    prod
);

  // The incoming sample is weighted now and passed to the next cell on the same step.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctl.take) begin
      sample <= ctl.clear ? '0 : sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      prod <= dspf_pkg::prod_t'(tap) * dspf_pkg::prod_t'(sample_in);
    end
  end

endmodule

>>> sv/dspf_sum.sv
module dspf_sum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_last,
  input  dspf_pkg::prod_vec_t   prods,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dspf_pkg::out_item_t   out_data
);

  localparam int W2 = dspf_pkg::PROD_W + 1;
  localparam int W3 = dspf_pkg::PROD_W + 2;
  localparam int SW = dspf_pkg::SUM_W;
  localparam logic signed [SW-1:0] ROUND_BIAS = SW'(1 << (dspf_pkg::FRAC_SHIFT - 1));
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (dspf_pkg::DATA_W - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (dspf_pkg::DATA_W - 1));

  logic                 v2, l2, v3, l3;
  logic signed [W2-1:0] p2 [4];
  logic signed [W3-1:0] p3 [2];
  logic                 r_out, r3, r2;
  logic signed [SW-1:0] acc, biased, shifted;
  dspf_pkg::sample_t    sat;

  assign r_out    = !out_valid || out_ready;
  assign r3       = !v3 || r_out;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  // Final add, round half up, saturate to the sample range.
  always_comb begin
    acc     = SW'(p3[0]) + SW'(p3[1]);
    biased  = acc + ROUND_BIAS;
    shifted = biased >>> dspf_pkg::FRAC_SHIFT;
    if (shifted > SAT_HI) begin
      sat = SAT_HI[dspf_pkg::DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[dspf_pkg::DATA_W-1:0];
    end else begin
      sat = shifted[dspf_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= in_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r_out) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      l2 <= in_last;
      for (int i = 0; i < 4; i++) begin
        p2[i] <= W2'($signed(prods[2*i])) + W2'($signed(prods[2*i+1]));
      end
    end
    if (r3) begin
      l3 <= l2;
      for (int i = 0; i < 2; i++) begin
        p3[i] <= W3'(p2[2*i]) + W3'(p2[2*i+1]);
      end
    end
    if (r_out) begin
      out_data.sample_out <= sat;
      out_data.last_out   <= l3;
    end
  end

endmodule

>>> sv/depthwise_same_pad_fir.sv
// A result leaves via the cell, adder-tree and output registers after the item that
// completes its window is accepted. One item per cycle unless out_ready stalls; an item
// marked end_of_sequence adds PAD steps of zero padding, during which in_ready is low.
// The cell row sets the rate, advancing one window position per cycle when not stalled.
// Reset (rst, synchronous, active high) clears the taps, delay cells, count and valids.
`include "depthwise_same_pad_fir_defines.svh"

module depthwise_same_pad_fir (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [dspf_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  logic [dspf_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dspf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dspf_pkg::out_item_t                 out_data
);

  // The sequencer runs in one of two modes. In streaming mode the cell row takes the
  // incoming item; after an end-marked item it switches to flushing and pushes PAD zero
  // samples through the row so the trailing outputs of the sequence come out.
  typedef enum logic [1:0] {
    ST_STREAM = 2'b01,
    ST_FLUSH  = 2'b10
  } seq_state_t;

  localparam int SW = dspf_pkg::SEEN_W;

  dspf_pkg::sample_t    taps [dspf_pkg::NREG];
  seq_state_t           state;
  logic [SW-1:0]        seen;
  logic [SW-1:0]        flush_left;
  logic                 s1_valid, s1_last;

  logic                 flushing, src_valid, s1_ready, take, emit, final_flush;
  logic                 sum_in_ready;
  dspf_pkg::sample_t    src_sample;
  dspf_pkg::cell_ctl_t  ctl;
  dspf_pkg::sample_t    chain [dspf_pkg::NCELL+1];
  dspf_pkg::sample_t    tail;
  dspf_pkg::prod_vec_t  prods;

  // Tap registers. Writes to an index beyond the tap list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dspf_pkg::NREG; i++) begin
        taps[i] <= '0;
      end
    end else if (cfg_wr_en && (cfg_addr < dspf_pkg::REG_IDX_W'(dspf_pkg::NREG))) begin
      taps[cfg_addr] <= cfg_wdata;
    end
  end

  // The source of each step is either the input item or a padding zero.
  // A step produces an output only once PAD samples of the sequence are in the row,
  // so that the center of the window sits on a real sample. The third padding step
  // is always the final output of the sequence and also wipes the row.
  assign flushing    = (state == ST_FLUSH);
  assign src_valid   = flushing || in_valid;
  assign src_sample  = flushing ? '0 : in_data.sample_in;
  assign s1_ready    = !s1_valid || sum_in_ready;
  assign take        = src_valid && s1_ready;
  assign in_ready    = s1_ready && !flushing;
  assign emit        = (seen == SW'(dspf_pkg::PAD));
  assign final_flush = flushing && (flush_left == SW'(1));
  assign ctl.take    = take;
  assign ctl.clear   = final_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_STREAM;
      seen       <= '0;
      flush_left <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (take) begin
        if (final_flush) begin
          seen <= '0;
        end else if (!emit) begin
          seen <= seen + SW'(1);
        end
        case (state)
          ST_STREAM: begin
            if (in_data.end_of_sequence) begin
              state      <= ST_FLUSH;
              flush_left <= SW'(dspf_pkg::PAD);
            end
          end
          ST_FLUSH: begin
            flush_left <= flush_left - SW'(1);
            if (final_flush) begin
              state <= ST_STREAM;
            end
          end
          default: begin
            state <= ST_STREAM;
          end
        endcase
      end
      if (s1_ready) begin
        s1_valid <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_last <= final_flush;
    end
  end

  // The cell row. Cell j sees the sample j positions back from the newest one,
  // weights it with the matching tap and hands it on to cell j+1.
  assign chain[0] = src_sample;
  assign tail     = chain[dspf_pkg::NCELL];

  for (genvar j = 0; j < dspf_pkg::LANES; j++) begin : g_lane
    if (j < dspf_pkg::NCELL) begin : g_cell
      localparam int K = 2 * dspf_pkg::PAD - j;
      dspf_pkg::sample_t tap_sel;

      if (K < dspf_pkg::TAPS) begin : g_tap
        assign tap_sel = taps[K];
      end else begin : g_notap
        assign tap_sel = '0;
      end

      dspf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .tap       (tap_sel),
        .sample_in (chain[j]),
        .sample    (chain[j+1]),
        .prod      (prods[j])
      );
    end else begin : g_pad
      assign prods[j] = '0;
    end
  end

  // Adder tree, rounding, saturation and the output register.
  dspf_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (sum_in_ready),
    .in_last   (s1_last),
    .prods     (prods),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `DSPF_ASSERT_NEXT(a_eos_blocks_input, in_valid && in_ready && in_data.end_of_sequence, !in_ready, "input taken right after an end-marked item")
  `DSPF_ASSERT_NEXT(a_flush_end_marks, take && ctl.clear, s1_valid && s1_last, "final padding step did not produce the marked output")
  `DSPF_ASSERT_NEXT(a_flush_end_clears, take && ctl.clear, (seen == '0) && (tail == '0), "row or count not cleared after a sequence")
  `DSPF_ASSERT_NOW(a_flush_count_live, flushing, flush_left != '0, "flushing with no padding steps left")

endmodule
